// ===== src/flptw_pkg.sv =====
// shared types, constants and the control store for the page table walker
// depends on nothing; imported by the walker core and the testbench
package flptw_pkg;

  localparam int TABLE_FRAMES      = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
  localparam int FRAME_W           = $clog2(TABLE_FRAMES);
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W            = FRAME_W + IDX_W;
  localparam int WORD_W            = 64;
  localparam int PA_W              = 63;
  localparam int ROOT_W            = 4;
  localparam int CANON_SHIFT       = 47;

  localparam logic [16:0]       CANON_HIGH  = 17'h1FFFF;
  localparam logic [WORD_W-1:0] BIT_TOP     = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] MASK_1G     = 64'h0000_0000_3FFF_FFFF;
  localparam logic [WORD_W-1:0] MASK_2M     = 64'h0000_0000_001F_FFFF;
  localparam logic [WORD_W-1:0] MASK_4K     = 64'h0000_0000_0000_0FFF;
  localparam int                BIT_PRESENT = 0;
  localparam int                BIT_HUGE    = 7;

  typedef enum logic [0:0] {
    KIND_WRITE     = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONCANON  = 2'd1,
    ST_UNMAPPED  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } page_size_t;

  typedef enum logic [1:0] {
    LVL_ROOT = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  typedef struct packed {
    kind_t             kind;
    logic [12:0]       word_index;
    logic [WORD_W-1:0] word_value;
    logic [WORD_W-1:0] virtual_address;
  } item_t;

  typedef struct packed {
    status_t         status;
    logic [PA_W-1:0] physical_address;
    page_size_t      page_size_code;
  } result_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_L0   = 3'd1;
  localparam step_t STEP_L1   = 3'd2;
  localparam step_t STEP_L2   = 3'd3;
  localparam step_t STEP_L3   = 3'd4;

  // one control word per sequencer step
  typedef struct packed {
    logic   eval;
    level_t level;
    logic   last;
    step_t  next;
  } ctrl_t;

  function automatic ctrl_t microcode(step_t step);
    ctrl_t c;
    c = '{eval: 1'b0, level: LVL_ROOT, last: 1'b0, next: STEP_IDLE};
    unique case (step)
      STEP_IDLE: c = '{eval: 1'b0, level: LVL_ROOT, last: 1'b0, next: STEP_L0};
      STEP_L0:   c = '{eval: 1'b1, level: LVL_ROOT, last: 1'b0, next: STEP_L1};
      STEP_L1:   c = '{eval: 1'b1, level: LVL_PDPT, last: 1'b0, next: STEP_L2};
      STEP_L2:   c = '{eval: 1'b1, level: LVL_PD,   last: 1'b0, next: STEP_L3};
      STEP_L3:   c = '{eval: 1'b1, level: LVL_PT,   last: 1'b1, next: STEP_IDLE};
      default:   c = '{eval: 1'b0, level: LVL_ROOT, last: 1'b0, next: STEP_IDLE};
    endcase
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] table_index(logic [WORD_W-1:0] va, level_t level);
    logic [IDX_W-1:0] idx;
    idx = '0;
    unique case (level)
      LVL_ROOT: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      LVL_PT:   idx = va[20:12];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// ===== src/flptw_ram.sv =====
// generic single-port ram with registered read data
// depends on nothing
module flptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/four_level_page_table_walker_core.sv =====
// four-level page table walker: microcoded sequencer over one table ram
// depends on flptw_pkg and flptw_ram
//
// A table write is taken while busy is low, and busy stays low. A translate raises
// busy the cycle after start and walks one table level per cycle, since each
// level waits on the registered read of the single-port table ram: done is
// registered from the step that ends the walk, L0 for a non-canonical address
// and L3 for a full 4 KiB walk, and busy stays high until then.
// The next start may be given in the cycle that done is high. done lasts
// exactly one cycle and result is valid only then; the receiver cannot hold it
// off, so it must capture result whenever done is high. cfg_ready is always
// high; the root frame should only be written while busy is low.
module four_level_page_table_walker_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  flptw_pkg::item_t                      item,
  output logic                                  busy,
  output logic                                  done,
  output flptw_pkg::result_t                    result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [flptw_pkg::ROOT_W-1:0]          cfg_data
);
  import flptw_pkg::*;

  logic [ROOT_W-1:0]  root_table_frame;
  step_t              step;
  step_t              step_next;
  ctrl_t              ctrl;
  logic [WORD_W-1:0]  va;
  logic               frame_ok;
  logic               canon;

  logic               accept;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [WORD_W-1:0]  entry;

  logic               finish;
  status_t            st;
  page_size_t         size_code;
  logic [WORD_W-1:0]  span_mask;
  logic [PA_W-1:0]    leaf_pa;
  logic               next_ok;
  logic [16:0]        va_top;
  logic               in_canon;
  logic               root_ok;

  assign cfg_ready = 1'b1;
  assign ctrl      = microcode(step);
  assign busy      = (step != STEP_IDLE);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_frame <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_table_frame <= cfg_data;
    end
  end

  assign va_top   = item.virtual_address[WORD_W-1:CANON_SHIFT];
  assign in_canon = (va_top == '0) || (va_top == CANON_HIGH);
  assign root_ok  = 32'(root_table_frame) < 32'(TABLE_FRAMES);
  assign next_ok  = entry[62:12] < 51'(TABLE_FRAMES);

  // ram port: table writes and the root read at accept, next level during a walk
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = {FRAME_W'(root_table_frame), table_index(item.virtual_address, LVL_ROOT)};
    if (step == STEP_IDLE) begin
      if (accept && item.kind == KIND_WRITE) begin
        ram_we   = 32'(item.word_index) < 32'(STORE_DEPTH);
        ram_addr = ADDR_W'(item.word_index);
      end
    end else begin
      ram_addr = {entry[12 +: FRAME_W], table_index(va, level_t'(2'(ctrl.level + 2'd1)))};
    end
  end

  flptw_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STORE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(item.word_value),
    .rdata(entry)
  );

  always_comb begin
    span_mask = MASK_4K;
    unique case (ctrl.level)
      LVL_PDPT: span_mask = MASK_1G;
      LVL_PD:   span_mask = MASK_2M;
      default:  span_mask = MASK_4K;
    endcase
  end

  assign leaf_pa = PA_W'((entry & ~(span_mask | BIT_TOP)) | (va & span_mask));

  // entry evaluation for the level in the current control word
  always_comb begin
    finish    = 1'b0;
    st        = ST_OK;
    size_code = SIZE_4K;
    if (ctrl.eval) begin
      priority if (!canon) begin
        finish = 1'b1;
        st     = ST_NONCANON;
      end else if (!frame_ok) begin
        finish = 1'b1;
        st     = ST_MALFORMED;
      end else if (ctrl.last) begin
        finish = 1'b1;
        st     = (entry == '0) ? ST_UNMAPPED : ST_OK;
      end else if (!entry[BIT_PRESENT]) begin
        finish = 1'b1;
        st     = ST_UNMAPPED;
      end else if (entry[BIT_HUGE]) begin
        finish = 1'b1;
        if (ctrl.level == LVL_ROOT) begin
          st = ST_MALFORMED;
        end else begin
          size_code = (ctrl.level == LVL_PDPT) ? SIZE_1G : SIZE_2M;
        end
      end else begin
        finish = 1'b0;
      end
    end
  end

  always_comb begin
    step_next = step;
    if (step == STEP_IDLE) begin
      if (accept && item.kind == KIND_TRANSLATE) begin
        step_next = ctrl.next;
      end
    end else if (finish) begin
      step_next = STEP_IDLE;
    end else begin
      step_next = ctrl.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_TRANSLATE) begin
      va       <= item.virtual_address;
      canon    <= in_canon;
      frame_ok <= root_ok;
    end else if (ctrl.eval && !finish) begin
      frame_ok <= next_ok;
    end
    if (finish) begin
      result.status           <= st;
      result.physical_address <= (st == ST_OK) ? leaf_pa : '0;
      result.page_size_code   <= (st == ST_OK) ? size_code : SIZE_4K;
    end
  end

  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a walk in progress");

  a_fault_fields_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |->
      result.physical_address == '0 && result.page_size_code == SIZE_4K)
    else $error("faulting transaction carries a nonzero address or size");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_WRITE |=> !done && !busy)
    else $error("table write produced a result or started a walk");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step == STEP_IDLE || step == STEP_L0 || step == STEP_L1 ||
    step == STEP_L2 || step == STEP_L3)
    else $error("sequencer step out of program");

  a_pt_final: assert property (@(posedge clk) disable iff (rst)
    step == STEP_L3 |=> step == STEP_IDLE && done)
    else $error("last level did not end the walk");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for four_level_page_table_walker_core
// builds page tables through table-write transactions and checks every translation
// depends on flptw_pkg and the walker core rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flptw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 425;

  class walk_tracker;
    logic [WORD_W-1:0] table_words [STORE_DEPTH];
    bit word_written [STORE_DEPTH];
    logic [ROOT_W-1:0] root_frame;
    result_t awaited_translations[$];
    int mismatches;
    int table_writes;
    int translations;
    int by_status [4];

    function new();
      root_frame = '0;
      mismatches = 0;
      table_writes = 0;
      translations = 0;
      foreach (by_status[i]) by_status[i] = 0;
      foreach (word_written[i]) word_written[i] = 1'b0;
    endfunction

    // walks the tables; stops early with the word index of the first unwritten read
    function result_t walk_tables(input logic [WORD_W-1:0] va, output int missing,
                                  output int miss_level);
      result_t r;
      logic [WORD_W-1:0] frm;
      logic [WORD_W-1:0] e;
      logic [WORD_W-1:0] span;
      int w;
      int sh;
      r.status = ST_OK;
      r.physical_address = '0;
      r.page_size_code = SIZE_4K;
      missing = -1;
      miss_level = 0;
      if (va[63:47] != '0 && va[63:47] != CANON_HIGH) begin
        r.status = ST_NONCANON;
        return r;
      end
      frm = WORD_W'(root_frame);
      for (int lvl = 0; lvl < 4; lvl++) begin
        sh = 39 - 9 * lvl;
        if (frm >= TABLE_FRAMES) begin
          r.status = ST_MALFORMED;
          return r;
        end
        w = int'(frm) * ENTRIES_PER_TABLE + int'((va >> sh) & 64'h1FF);
        if (!word_written[w]) begin
          missing = w;
          miss_level = lvl;
          return r;
        end
        e = table_words[w];
        span = (64'd1 << sh) - 64'd1;
        if (lvl == 3) begin
          if (e == '0) begin
            r.status = ST_UNMAPPED;
          end else begin
            r.physical_address = PA_W'((e & ~(span | BIT_TOP)) + (va & span));
          end
          return r;
        end
        if (!e[BIT_PRESENT]) begin
          r.status = ST_UNMAPPED;
          return r;
        end
        if (e[BIT_HUGE]) begin
          if (lvl == 0) begin
            r.status = ST_MALFORMED;
          end else begin
            r.physical_address = PA_W'((e & ~(span | BIT_TOP)) + (va & span));
            r.page_size_code = (lvl == 1) ? SIZE_1G : SIZE_2M;
          end
          return r;
        end
        frm = (e & ~(64'hFFF | BIT_TOP)) >> 12;
      end
      return r;
    endfunction

    function void note_item(item_t it);
      int miss;
      int lvl;
      if (it.kind == KIND_WRITE) begin
        if (it.word_index < STORE_DEPTH) begin
          table_words[it.word_index] = it.word_value;
          word_written[it.word_index] = 1'b1;
        end
        table_writes++;
      end else begin
        awaited_translations.push_back(walk_tables(it.virtual_address, miss, lvl));
        translations++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (awaited_translations.size() == 0) begin
        $error("result with no translation pending: status %0d pa %0h", got.status,
               got.physical_address);
        mismatches++;
        return;
      end
      exp = awaited_translations.pop_front();
      by_status[exp.status]++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.physical_address !== exp.physical_address) begin
        $error("physical_address: expected %0h, got %0h", exp.physical_address,
               got.physical_address);
        mismatches++;
      end
      if (got.page_size_code !== exp.page_size_code) begin
        $error("page_size_code: expected %0d, got %0d", exp.page_size_code,
               got.page_size_code);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ROOT_W-1:0] cfg_data = '0;

  walk_tracker tracker = new();
  int cycles = 0;
  int items_sent = 0;
  int root_writes = 0;
  int burst_left = 0;

  four_level_page_table_walker_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  // idle cycles before the next transaction, with bursts of back-to-back items
  function int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 30);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [IDX_W-1:0] small_index();
    if ($urandom_range(0, 7) == 0) return '1;
    return IDX_W'($urandom_range(0, 3));
  endfunction

  function automatic item_t rand_item(kind_t k);
    item_t it;
    it.kind = k;
    it.word_index = 13'($urandom);
    it.word_value = {$urandom, $urandom};
    it.virtual_address = {$urandom, $urandom};
    return it;
  endfunction

  // table entry for a given level: above the last level, mostly pointers to in-store frames
  function automatic logic [WORD_W-1:0] make_entry(int lvl);
    logic [WORD_W-1:0] e;
    int pick;
    pick = $urandom_range(0, 99);
    e = {$urandom, $urandom};
    if (lvl == 3) begin
      if (pick < 8) e = '0;
      else if (pick < 20) e[BIT_PRESENT] = 1'b0;
      return e;
    end
    if (pick < 68 || (lvl == 0 && pick < 76)) begin
      e[62:12] = 51'($urandom_range(0, TABLE_FRAMES - 1));
      e[BIT_PRESENT] = 1'b1;
      e[BIT_HUGE] = 1'b0;
    end else if (pick < 80) begin
      e[BIT_PRESENT] = 1'b1;
      e[BIT_HUGE] = 1'b1;
    end else if (pick < 90) begin
      e[BIT_PRESENT] = 1'b0;
    end else if (pick < 96) begin
      e[BIT_PRESENT] = 1'b1;
      e[BIT_HUGE] = 1'b0;
      e[16 + $urandom_range(0, 46)] = 1'b1;
    end
    return e;
  endfunction

  function automatic logic [WORD_W-1:0] make_va();
    logic [WORD_W-1:0] va;
    va = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 8) begin
      if (va[63:47] == '0 || va[63:47] == CANON_HIGH) va[62] = ~va[62];
      return va;
    end
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 99) < 65) va[47 - 9 * i -: 9] = small_index();
    end
    va[63:48] = {16{va[47]}};
    return va;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    tracker.note_item(it);
    items_sent++;
  endtask

  task automatic table_write(input int idx, input logic [WORD_W-1:0] value);
    item_t it;
    it = rand_item(KIND_WRITE);
    it.word_index = 13'(idx);
    it.word_value = value;
    send_item(it);
  endtask

  task automatic translate(input logic [WORD_W-1:0] va);
    item_t it;
    it = rand_item(KIND_TRANSLATE);
    it.virtual_address = va;
    send_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.awaited_translations.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_root(input logic [ROOT_W-1:0] frame);
    cfg_valid <= 1'b1;
    cfg_data <= frame;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.root_frame = frame;
    root_writes++;
  endtask

  // fills every entry the walk would read before it, then sends the translation
  task automatic random_translate();
    logic [WORD_W-1:0] va;
    int miss;
    int lvl;
    va = make_va();
    void'(tracker.walk_tables(va, miss, lvl));
    while (miss >= 0) begin
      table_write(miss, make_entry(lvl));
      void'(tracker.walk_tables(va, miss, lvl));
    end
    translate(va);
  endtask

  task automatic random_phase(input int count);
    item_t it;
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(rand_item(KIND_WRITE));
      end else if (pick < 15) begin
        it = rand_item(KIND_WRITE);
        it.word_index = {4'($urandom_range(0, TABLE_FRAMES - 1)), small_index()};
        it.word_value = make_entry($urandom_range(0, 3));
        send_item(it);
      end else begin
        random_translate();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_root('0);

    // root 0 -> pdpt frame 1 -> pd frame 2 -> pt frame 3
    table_write(0, 64'h8000_0000_0000_1003);
    table_write(512, 64'h0000_0000_0000_2003);
    table_write(1024, 64'h0000_0000_0000_3003);
    table_write(1536, 64'hFFFF_FFFF_FFFF_F001);
    translate(64'h0000_0000_0000_0ABC);
    table_write(513, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(64'h0000_0000_7FFF_FFFF);
    table_write(1025, 64'h7FFF_FFFF_FFE0_0081);
    translate(64'h0000_0000_003F_FFFF);
    table_write(1537, 64'h0);
    translate(64'h0000_0000_0000_1000);
    table_write(1538, 64'h0000_0000_0000_5000);
    translate(64'h0000_0000_0000_2123);
    table_write(1026, 64'h0000_0000_0000_0080);
    translate(64'h0000_0000_0040_0000);
    table_write(511, 64'h0000_0000_0000_0081);
    translate(64'hFFFF_FF80_0000_0000);
    table_write(1, 64'h0000_0000_0001_0003);
    translate(64'h0000_0080_0000_0000);
    table_write(2, 64'h0);
    translate(64'h0000_0100_0000_0000);
    translate(64'h0000_8000_0000_0000);
    translate(64'h8000_0000_0000_0000);

    drain();
    write_root('1);
    random_phase(PHASE_ITEMS);
    drain();
    write_root('0);
    random_phase(PHASE_ITEMS);
    drain();
    write_root(ROOT_W'($urandom_range(1, 14)));
    random_phase(PHASE_ITEMS);
    drain();
    write_root('1);
    random_phase(PHASE_ITEMS);
    drain();

    if (tracker.awaited_translations.size() != 0) begin
      $error("%0d translations never returned", tracker.awaited_translations.size());
      tracker.mismatches++;
    end
    $display("summary: %0d transactions (%0d table writes, %0d translations), %0d root writes",
             items_sent, tracker.table_writes, tracker.translations, root_writes);
    $display("summary: ok %0d, non-canonical %0d, unmapped %0d, malformed %0d",
             tracker.by_status[ST_OK], tracker.by_status[ST_NONCANON],
             tracker.by_status[ST_UNMAPPED], tracker.by_status[ST_MALFORMED]);
    if (tracker.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
